@@ design/fsa_pkg.sv @@
// Package with the types and constants of the fragmented sparse array.
`timescale 1ns / 1ps

package fsa_pkg;

  localparam int MAX_FRAGMENTS       = 16;
  localparam int MAX_FRAGMENT_LENGTH = 16;
  localparam int DATA_WIDTH          = 32;

  localparam int OP_WIDTH        = 3;
  localparam int INDEX_WIDTH     = 10;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 5;
  localparam int FILL_WIDTH      = 5;
  localparam int COUNT_WIDTH     = 9;

  localparam logic [FILL_WIDTH-1:0]  FILL_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] TOTAL_MAX = '1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_SET          = 3'd0,
    OP_GET          = 3'd1,
    OP_DELETE       = 3'd2,
    OP_IS_SET       = 3'd3,
    OP_CONTAINS_KEY = 3'd4,
    OP_CLEAR        = 3'd5
  } op_e;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_FRAGMENTS_IN_USE   = 1'd0,
    REG_CELLS_PER_FRAGMENT = 1'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_LOOK,
    ST_FILL,
    ST_READ,
    ST_SCAN_FRAG,
    ST_SCAN_CELL,
    ST_EMIT
  } state_e;

endpackage

@@ design/fsa_ram.sv @@
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module fsa_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fragmented_sparse_array.sv @@
// Top level of the fragmented sparse array with its sequencer and shared divider step.
//
//   Channel  Signals                                         Moves
//   in       in_valid_i / in_ready_o                         operation, flat_index, key_value
//   out      out_valid_o / out_ready_i                       status, read_value, found_flag,
//                                                            used_cells, allocated_cells
//   cfg      cfg_valid_i / cfg_ready_o                       cfg_index_i, cfg_data_i
//
// One item is worked at a time. Get, delete, is_set and a set into an active fragment pass
// through the check, divider, lookup and read states, the divider settling one quotient bit a
// cycle. A set that activates a fragment instead writes every cell of it in the fill state, one
// cell a cycle. Contains_key scans each fragment in use and each cell of each active fragment,
// ending at the first match. Clear and unknown operations go straight to emit. Reset clears counts
// at once. A waiting result sits in the output register while the next item is accepted.
`timescale 1ns / 1ps

module fragmented_sparse_array #(
  parameter int MaxFragments      = fsa_pkg::MAX_FRAGMENTS,
  parameter int MaxFragmentLength = fsa_pkg::MAX_FRAGMENT_LENGTH,
  parameter int DataWidth         = fsa_pkg::DATA_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [fsa_pkg::OP_WIDTH-1:0]         operation_i,
  input  logic signed [fsa_pkg::INDEX_WIDTH-1:0] flat_index_i,
  input  logic signed [DataWidth-1:0]          key_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 status_o,
  output logic signed [DataWidth-1:0]          read_value_o,
  output logic                                 found_flag_o,
  output logic [fsa_pkg::COUNT_WIDTH-1:0]      used_cells_o,
  output logic [fsa_pkg::COUNT_WIDTH-1:0]      allocated_cells_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fsa_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index_i,
  input  logic [fsa_pkg::CFG_DATA_WIDTH-1:0]   cfg_data_i
);

  localparam int QW    = (MaxFragments > 1) ? $clog2(MaxFragments) : 1;
  localparam int StepW = (QW > 1) ? $clog2(QW) : 1;
  localparam int FiuW  = $clog2(MaxFragments + 1);
  localparam int LenW  = $clog2(MaxFragmentLength + 1);
  localparam int OffW  = (MaxFragmentLength > 1) ? $clog2(MaxFragmentLength) : 1;
  localparam int Depth = MaxFragments * MaxFragmentLength;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int MagW  = fsa_pkg::INDEX_WIDTH - 1;
  localparam int CmpW  = (MagW > LenW + QW) ? MagW : LenW + QW;
  localparam int LimW  = (MagW > FiuW + LenW) ? MagW : FiuW + LenW;
  localparam int ActW  = FiuW;
  localparam int CW    = fsa_pkg::COUNT_WIDTH;
  localparam int FW    = fsa_pkg::FILL_WIDTH;

  localparam logic [DataWidth-1:0] Sentinel   = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [AddrW-1:0]     LenStride  = AddrW'(MaxFragmentLength);
  localparam logic [StepW-1:0]     StepTop    = StepW'(QW - 1);

  fsa_pkg::state_e state_q, state_d;

  fsa_pkg::op_e            op_q;
  logic [fsa_pkg::INDEX_WIDTH-1:0] idx_q;
  logic [DataWidth-1:0]    key_q;

  logic [FiuW-1:0]         fiu_q;
  logic [LenW-1:0]         cpf_q;

  logic [MaxFragments-1:0] active_q;
  logic [FW-1:0]           fill_q [MaxFragments];
  logic [CW-1:0]           total_q;
  logic [ActW-1:0]         act_total_q;

  logic [CmpW-1:0]         rem_q;
  logic [StepW-1:0]        step_q;
  logic [FiuW-1:0]         frag_q;
  logic [OffW-1:0]         cnt_q;

  logic                    res_status_q;
  logic [DataWidth-1:0]    res_value_q;
  logic                    res_found_q;

  logic                    out_valid_q;
  logic                    out_status_q;
  logic [DataWidth-1:0]    out_value_q;
  logic                    out_found_q;
  logic [CW-1:0]           out_used_q;
  logic [CW-1:0]           out_alloc_q;

  logic                    ram_we;
  logic [AddrW-1:0]        ram_waddr;
  logic [DataWidth-1:0]    ram_wdata;
  logic [AddrW-1:0]        ram_raddr;
  logic [DataWidth-1:0]    ram_rdata;

  logic                    in_fire;
  logic                    cfg_fire;
  logic                    emit_load;
  logic                    idx_ok;
  logic                    index_op;
  logic [CmpW-1:0]         div_sub;
  logic                    div_take;
  logic                    frag_act;
  logic [FW-1:0]           frag_fill;
  logic [OffW-1:0]         off;
  logic                    cnt_last;
  logic                    cell_empty;
  logic                    frag_in_range;
  logic [FiuW-1:0]         fiu_new;
  logic [LenW-1:0]         cpf_new;
  logic [FW-1:0]           fill_dec;

  function automatic logic [AddrW-1:0] cell_addr(input logic [FiuW-1:0] f,
                                                 input logic [OffW-1:0] o);
    cell_addr = AddrW'(f[QW-1:0]) * LenStride + AddrW'(o);
  endfunction

  assign in_ready_o  = (state_q == fsa_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign emit_load   = (state_q == fsa_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);

  assign idx_ok   = !idx_q[MagW] &&
                    (LimW'(idx_q[MagW-1:0]) < LimW'(fiu_q) * LimW'(cpf_q));
  assign index_op = op_q inside {fsa_pkg::OP_SET, fsa_pkg::OP_GET,
                                 fsa_pkg::OP_DELETE, fsa_pkg::OP_IS_SET};
  assign div_sub  = CmpW'(cpf_q) << step_q;
  assign div_take = (rem_q >= div_sub);

  assign frag_act      = active_q[frag_q[QW-1:0]];
  assign frag_fill     = fill_q[frag_q[QW-1:0]];
  assign off           = rem_q[OffW-1:0];
  assign cnt_last      = ((LenW+1)'(cnt_q) + (LenW+1)'(1)) == (LenW+1)'(cpf_q);
  assign cell_empty    = (ram_rdata == Sentinel);
  assign frag_in_range = (frag_q < fiu_q);
  assign fill_dec      = (frag_fill != '0) ? frag_fill - FW'(1) : '0;

  always_comb begin
    if (cfg_data_i == '0) begin
      fiu_new = FiuW'(1);
      cpf_new = LenW'(1);
    end else begin
      fiu_new = (int'(cfg_data_i) > MaxFragments) ? FiuW'(MaxFragments) : FiuW'(cfg_data_i);
      cpf_new = (int'(cfg_data_i) > MaxFragmentLength) ?
                LenW'(MaxFragmentLength) : LenW'(cfg_data_i);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fsa_pkg::ST_IDLE: begin
        if (in_fire) state_d = fsa_pkg::ST_CHECK;
      end
      fsa_pkg::ST_CHECK: begin
        if (index_op) begin
          state_d = idx_ok ? fsa_pkg::ST_DIV : fsa_pkg::ST_EMIT;
        end else if (op_q == fsa_pkg::OP_CONTAINS_KEY) begin
          state_d = fsa_pkg::ST_SCAN_FRAG;
        end else begin
          state_d = fsa_pkg::ST_EMIT;
        end
      end
      fsa_pkg::ST_DIV: begin
        if (step_q == '0) state_d = fsa_pkg::ST_LOOK;
      end
      fsa_pkg::ST_LOOK: begin
        state_d = (op_q == fsa_pkg::OP_SET && !frag_act) ? fsa_pkg::ST_FILL : fsa_pkg::ST_READ;
      end
      fsa_pkg::ST_FILL: begin
        if (cnt_last) state_d = fsa_pkg::ST_EMIT;
      end
      fsa_pkg::ST_READ: begin
        state_d = fsa_pkg::ST_EMIT;
      end
      fsa_pkg::ST_SCAN_FRAG: begin
        if (!frag_in_range) begin
          state_d = fsa_pkg::ST_EMIT;
        end else if (frag_act) begin
          state_d = fsa_pkg::ST_SCAN_CELL;
        end
      end
      fsa_pkg::ST_SCAN_CELL: begin
        if (ram_rdata == key_q) begin
          state_d = fsa_pkg::ST_EMIT;
        end else if (cnt_last) begin
          state_d = fsa_pkg::ST_SCAN_FRAG;
        end
      end
      fsa_pkg::ST_EMIT: begin
        if (emit_load) state_d = fsa_pkg::ST_IDLE;
      end
      default: state_d = fsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr(frag_q, off);
    ram_wdata = key_q;
    ram_raddr = cell_addr(frag_q, off);
    case (state_q)
      fsa_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(frag_q, cnt_q);
        ram_wdata = (cnt_q == off) ? key_q : Sentinel;
      end
      fsa_pkg::ST_READ: begin
        if (op_q == fsa_pkg::OP_SET) begin
          ram_we = 1'b1;
        end else if (op_q == fsa_pkg::OP_DELETE && frag_act && !cell_empty) begin
          ram_we    = 1'b1;
          ram_wdata = Sentinel;
        end
      end
      fsa_pkg::ST_SCAN_FRAG: begin
        ram_raddr = cell_addr(frag_q, '0);
      end
      fsa_pkg::ST_SCAN_CELL: begin
        ram_raddr = cell_addr(frag_q, cnt_q + OffW'(1));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q       <= FiuW'(MaxFragments);
      cpf_q       <= LenW'(MaxFragmentLength);
      active_q    <= '0;
      fill_q      <= '{default: '0};
      total_q     <= '0;
      act_total_q <= '0;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        fsa_pkg::REG_FRAGMENTS_IN_USE:   fiu_q <= fiu_new;
        fsa_pkg::REG_CELLS_PER_FRAGMENT: cpf_q <= cpf_new;
        default: ;
      endcase
      active_q    <= '0;
      fill_q      <= '{default: '0};
      total_q     <= '0;
      act_total_q <= '0;
    end else begin
      case (state_q)
        fsa_pkg::ST_CHECK: begin
          if (op_q == fsa_pkg::OP_CLEAR) begin
            active_q    <= '0;
            fill_q      <= '{default: '0};
            total_q     <= '0;
            act_total_q <= '0;
          end
        end
        fsa_pkg::ST_LOOK: begin
          if (op_q == fsa_pkg::OP_SET && !frag_act) begin
            active_q[frag_q[QW-1:0]] <= 1'b1;
            act_total_q              <= act_total_q + ActW'(1);
          end
        end
        fsa_pkg::ST_FILL: begin
          if (cnt_last) begin
            if (total_q != fsa_pkg::TOTAL_MAX) total_q <= total_q + CW'(1);
            if (frag_fill != fsa_pkg::FILL_MAX) fill_q[frag_q[QW-1:0]] <= frag_fill + FW'(1);
          end
        end
        fsa_pkg::ST_READ: begin
          if (op_q == fsa_pkg::OP_SET && cell_empty) begin
            if (total_q != fsa_pkg::TOTAL_MAX) total_q <= total_q + CW'(1);
            if (frag_fill != fsa_pkg::FILL_MAX) fill_q[frag_q[QW-1:0]] <= frag_fill + FW'(1);
          end else if (op_q == fsa_pkg::OP_DELETE && frag_act && !cell_empty) begin
            if (total_q != '0) total_q <= total_q - CW'(1);
            fill_q[frag_q[QW-1:0]] <= fill_dec;
            if (fill_dec == '0) begin
              active_q[frag_q[QW-1:0]] <= 1'b0;
              if (act_total_q != '0) act_total_q <= act_total_q - ActW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      fsa_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_q  <= fsa_pkg::op_e'(operation_i);
          idx_q <= flat_index_i;
          key_q <= key_value_i;
        end
      end
      fsa_pkg::ST_CHECK: begin
        res_status_q <= fsa_pkg::STATUS_OK;
        res_value_q  <= '0;
        res_found_q  <= 1'b0;
        rem_q        <= CmpW'(idx_q[MagW-1:0]);
        step_q       <= StepTop;
        frag_q       <= '0;
        if (index_op) begin
          if (!idx_ok) res_status_q <= fsa_pkg::STATUS_FAIL;
        end else if (op_q != fsa_pkg::OP_CONTAINS_KEY && op_q != fsa_pkg::OP_CLEAR) begin
          res_status_q <= fsa_pkg::STATUS_FAIL;
        end
      end
      fsa_pkg::ST_DIV: begin
        if (div_take) begin
          rem_q          <= rem_q - div_sub;
          frag_q[step_q] <= 1'b1;
        end
        step_q <= step_q - StepW'(1);
      end
      fsa_pkg::ST_LOOK: begin
        cnt_q <= '0;
      end
      fsa_pkg::ST_FILL: begin
        cnt_q <= cnt_q + OffW'(1);
      end
      fsa_pkg::ST_READ: begin
        case (op_q)
          fsa_pkg::OP_GET: begin
            res_value_q <= frag_act ? ram_rdata : Sentinel;
          end
          fsa_pkg::OP_DELETE: begin
            if (!frag_act || cell_empty) res_status_q <= fsa_pkg::STATUS_FAIL;
          end
          fsa_pkg::OP_IS_SET: begin
            res_found_q <= frag_act && !cell_empty;
          end
          default: ;
        endcase
      end
      fsa_pkg::ST_SCAN_FRAG: begin
        cnt_q <= '0;
        if (frag_in_range && !frag_act) frag_q <= frag_q + FiuW'(1);
      end
      fsa_pkg::ST_SCAN_CELL: begin
        if (ram_rdata == key_q) begin
          res_found_q <= 1'b1;
        end else if (cnt_last) begin
          frag_q <= frag_q + FiuW'(1);
        end else begin
          cnt_q <= cnt_q + OffW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_found_q  <= res_found_q;
      out_used_q   <= total_q;
      out_alloc_q  <= CW'(act_total_q) * CW'(cpf_q);
    end
  end

  fsa_ram #(
    .Width (DataWidth),
    .Depth (Depth)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign read_value_o      = out_value_q;
  assign found_flag_o      = out_found_q;
  assign used_cells_o      = out_used_q;
  assign allocated_cells_o = out_alloc_q;

endmodule

@@ tb/tb_fragmented_sparse_array.sv @@
// Self-checking testbench for the fragmented sparse array with a built-in predictor.
`timescale 1ns / 1ps

module tb_fragmented_sparse_array;
  import fsa_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int END_WAIT    = 400;
  localparam int STORE_DEPTH = MAX_FRAGMENTS * MAX_FRAGMENT_LENGTH;

  localparam logic [OP_WIDTH-1:0]   OP_UNKNOWN_A = 3'd6;
  localparam logic [OP_WIDTH-1:0]   OP_UNKNOWN_B = 3'd7;
  localparam logic [DATA_WIDTH-1:0] SENTINEL     = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] KEY_MAX      = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] KEY_ALL_ONES = '1;

  typedef struct packed {
    logic [OP_WIDTH-1:0]    op;
    logic [INDEX_WIDTH-1:0] index;
    logic [DATA_WIDTH-1:0]  key;
  } request_t;

  typedef struct packed {
    logic                   status;
    logic [DATA_WIDTH-1:0]  read_value;
    logic                   found;
    logic [COUNT_WIDTH-1:0] used_cells;
    logic [COUNT_WIDTH-1:0] allocated_cells;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic [OP_WIDTH-1:0]        in_op = '0;
  logic [INDEX_WIDTH-1:0]     in_index = '0;
  logic [DATA_WIDTH-1:0]      in_key = '0;
  logic                       out_ready = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  logic                   in_ready;
  logic                   out_valid;
  logic                   status;
  logic [DATA_WIDTH-1:0]  read_value;
  logic                   found_flag;
  logic [COUNT_WIDTH-1:0] used_cells;
  logic [COUNT_WIDTH-1:0] allocated_cells;
  logic                   cfg_ready;

  request_t request_q[$];
  outcome_t outcome_q[$];
  bit       in_flight = 1'b0;
  int       in_gap_pct = 20;
  int       out_stall_pct = 20;
  int       gap_left = 0;
  int       stall_left = 0;
  int       errors = 0;
  int       cycle_count = 0;

  logic [DATA_WIDTH-1:0]  cell_store [STORE_DEPTH];
  bit                     frag_active [MAX_FRAGMENTS];
  logic [FILL_WIDTH-1:0]  frag_fill [MAX_FRAGMENTS];
  logic [COUNT_WIDTH-1:0] total_fill;
  int                     active_total;
  int                     num_frags = MAX_FRAGMENTS;
  int                     frag_len = MAX_FRAGMENT_LENGTH;

  fragmented_sparse_array dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (in_op),
    .flat_index_i     (in_index),
    .key_value_i      (in_key),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .read_value_o     (read_value),
    .found_flag_o     (found_flag),
    .used_cells_o     (used_cells),
    .allocated_cells_o(allocated_cells),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void clear_array();
    foreach (frag_active[f]) begin
      frag_active[f] = 1'b0;
      frag_fill[f] = '0;
    end
    total_fill = '0;
    active_total = 0;
  endfunction

  function automatic outcome_t perform_op(logic [OP_WIDTH-1:0] op,
                                          logic [INDEX_WIDTH-1:0] idx,
                                          logic [DATA_WIDTH-1:0] key);
    outcome_t res;
    bit idx_ok;
    int frag, offs, addr, f, c;
    res = '0;
    idx_ok = 1'b0;
    frag = 0;
    offs = 0;
    addr = 0;
    if (!idx[INDEX_WIDTH-1] && int'(idx) < num_frags * frag_len) begin
      idx_ok = 1'b1;
      frag = int'(idx) / frag_len;
      offs = int'(idx) % frag_len;
      addr = frag * MAX_FRAGMENT_LENGTH + offs;
    end
    case (op)
      OP_SET: begin
        if (!idx_ok) begin
          res.status = STATUS_FAIL;
        end else begin
          if (!frag_active[frag]) begin
            frag_active[frag] = 1'b1;
            active_total++;
            for (c = 0; c < frag_len; c++) cell_store[frag * MAX_FRAGMENT_LENGTH + c] = SENTINEL;
          end
          if (cell_store[addr] == SENTINEL) begin
            if (total_fill < TOTAL_MAX) total_fill++;
            if (frag_fill[frag] < FILL_MAX) frag_fill[frag]++;
          end
          cell_store[addr] = key;
        end
      end
      OP_GET: begin
        if (!idx_ok) res.status = STATUS_FAIL;
        else res.read_value = frag_active[frag] ? cell_store[addr] : SENTINEL;
      end
      OP_DELETE: begin
        if (!idx_ok || !frag_active[frag] || cell_store[addr] == SENTINEL) begin
          res.status = STATUS_FAIL;
        end else begin
          cell_store[addr] = SENTINEL;
          if (total_fill > 0) total_fill--;
          if (frag_fill[frag] > 0) frag_fill[frag]--;
          if (frag_fill[frag] == 0) begin
            frag_active[frag] = 1'b0;
            if (active_total > 0) active_total--;
          end
        end
      end
      OP_IS_SET: begin
        if (!idx_ok) res.status = STATUS_FAIL;
        else res.found = frag_active[frag] && cell_store[addr] != SENTINEL;
      end
      OP_CONTAINS_KEY: begin
        for (f = 0; f < num_frags; f++) begin
          if (frag_active[f]) begin
            for (c = 0; c < frag_len; c++) begin
              if (cell_store[f * MAX_FRAGMENT_LENGTH + c] == key) res.found = 1'b1;
            end
          end
        end
      end
      OP_CLEAR: clear_array();
      default: res.status = STATUS_FAIL;
    endcase
    res.used_cells = total_fill;
    res.allocated_cells = COUNT_WIDTH'(active_total * frag_len);
    return res;
  endfunction

  function automatic void check_field(string field, logic [DATA_WIDTH-1:0] want,
                                      logic [DATA_WIDTH-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endfunction

  // Driver: presents queued items and predicts each one as it is accepted.
  always @(posedge clk or negedge rst_n) begin : driver
    request_t nxt;
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_flight = 1'b0;
      gap_left = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        outcome_q.push_back(perform_op(in_op, in_index, in_key));
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) begin
          gap_left = $urandom_range(16);
        end else if (request_q.size() > 0) begin
          nxt = request_q.pop_front();
          in_op <= nxt.op;
          in_index <= nxt.index;
          in_key <= nxt.key;
          busy = 1'b1;
        end
      end
      in_flight = busy;
      in_valid <= busy;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk or negedge rst_n) begin : monitor
    outcome_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result item arrived with nothing outstanding", $time);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(status));
          check_field("read_value", want.read_value, read_value);
          check_field("found_flag", DATA_WIDTH'(want.found), DATA_WIDTH'(found_flag));
          check_field("used_cells", DATA_WIDTH'(want.used_cells), DATA_WIDTH'(used_cells));
          check_field("allocated_cells", DATA_WIDTH'(want.allocated_cells),
                      DATA_WIDTH'(allocated_cells));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (out_stall_pct > 0 && $urandom_range(99) < out_stall_pct) begin
        stall_left = $urandom_range(16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_fragmented_sparse_array failed");
      $finish;
    end
  end

  task automatic add_item(logic [OP_WIDTH-1:0] op, logic [INDEX_WIDTH-1:0] idx,
                          logic [DATA_WIDTH-1:0] key);
    request_t req;
    req.op = op;
    req.index = idx;
    req.key = key;
    request_q.push_back(req);
  endtask

  task automatic drain();
    while (request_q.size() != 0 || in_flight || outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e which, logic [CFG_DATA_WIDTH-1:0] value);
    int v;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    v = int'(value);
    if (v == 0) v = 1;
    if (which == REG_FRAGMENTS_IN_USE) num_frags = (v > MAX_FRAGMENTS) ? MAX_FRAGMENTS : v;
    else frag_len = (v > MAX_FRAGMENT_LENGTH) ? MAX_FRAGMENT_LENGTH : v;
    clear_array();
  endtask

  // Well-formed traffic on recently written cells and a small key pool, plus noise.
  // With a nonzero sentinel share the counts are driven into saturation.
  task automatic queue_random(int count, int sentinel_pct);
    logic [INDEX_WIDTH-1:0] recent[$];
    logic [DATA_WIDTH-1:0]  pool [8];
    logic [OP_WIDTH-1:0]    op;
    logic [INDEX_WIDTH-1:0] idx;
    logic [DATA_WIDTH-1:0]  key;
    int span, r;
    span = num_frags * frag_len;
    foreach (pool[i]) pool[i] = $urandom;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 60 && recent.size() > 0) idx = recent[$urandom_range(recent.size() - 1)];
      else if (r < 90) idx = INDEX_WIDTH'($urandom_range(span - 1));
      else idx = INDEX_WIDTH'($urandom_range(1023));
      r = $urandom_range(99);
      if (r < 45) key = pool[$urandom_range(7)];
      else if (r < 55) key = SENTINEL;
      else if (r < 58) key = KEY_MAX;
      else if (r < 61) key = '0;
      else if (r < 64) key = KEY_ALL_ONES;
      else key = $urandom;
      if ($urandom_range(99) < sentinel_pct) begin
        op = OP_SET;
        key = SENTINEL;
        idx = INDEX_WIDTH'($urandom_range(span - 1));
      end else begin
        r = $urandom_range(99);
        if (r < 34) op = OP_SET;
        else if (r < 50) op = OP_GET;
        else if (r < 70) op = OP_DELETE;
        else if (r < 80) op = OP_IS_SET;
        else if (r < 90) op = OP_CONTAINS_KEY;
        else if (r < 93) op = (sentinel_pct == 0) ? OP_CLEAR : OP_GET;
        else if (r < 96) op = $urandom_range(1) ? OP_UNKNOWN_A : OP_UNKNOWN_B;
        else op = OP_WIDTH'($urandom_range(7));
      end
      if (op == OP_SET) begin
        recent.push_back(idx);
        if (recent.size() > 24) void'(recent.pop_front());
      end
      add_item(op, idx, key);
    end
  endtask

  initial begin : sequencer
    int frag_w [8];
    int len_w [8];
    int gap_w [8];
    int stall_w [8];
    int count_w [8];
    frag_w  = '{1, 16, 1, 0, 17, -2, -1, 16};
    len_w   = '{1, -1, 16, 31, 3, -2, 7, 16};
    gap_w   = '{20, 40, 5, 0, 25, 10, 30, 0};
    stall_w = '{20, 5, 40, 0, 25, 10, 15, 0};
    count_w = '{150, 150, 150, 150, 150, 150, 150, 200};
    clear_array();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_item(OP_GET, 10'd0, '0);
    add_item(OP_DELETE, 10'd0, '0);
    add_item(OP_IS_SET, 10'd0, '0);
    add_item(OP_SET, 10'd0, KEY_MAX);
    add_item(OP_GET, 10'd1, '0);
    add_item(OP_DELETE, 10'd1, '0);
    add_item(OP_CONTAINS_KEY, 10'd0, KEY_MAX);
    add_item(OP_CONTAINS_KEY, 10'd0, SENTINEL);
    add_item(OP_SET, 10'd255, SENTINEL);
    add_item(OP_SET, 10'd255, SENTINEL);
    add_item(OP_IS_SET, 10'd255, '0);
    add_item(OP_SET, 10'd17, '0);
    add_item(OP_SET, 10'd17, KEY_ALL_ONES);
    add_item(OP_GET, 10'd17, '0);
    add_item(OP_SET, 10'h3FF, 32'h0000_0001);
    add_item(OP_GET, 10'h200, '0);
    add_item(OP_SET, 10'h1FF, 32'h0000_0001);
    add_item(OP_IS_SET, 10'd256, '0);
    add_item(OP_DELETE, 10'd0, '0);
    add_item(OP_GET, 10'd0, '0);
    add_item(OP_CONTAINS_KEY, 10'd0, KEY_MAX);
    add_item(OP_UNKNOWN_A, 10'd17, KEY_ALL_ONES);
    add_item(OP_UNKNOWN_B, 10'h3FF, SENTINEL);
    add_item(OP_CONTAINS_KEY, 10'd0, 32'h0000_0001);
    add_item(OP_CLEAR, 10'd0, '0);
    add_item(OP_GET, 10'd17, '0);
    drain();

    write_reg(REG_FRAGMENTS_IN_USE, 5'd2);
    write_reg(REG_CELLS_PER_FRAGMENT, 5'd16);
    queue_random(620, 92);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (frag_w[p] == -2) begin
        write_reg(REG_FRAGMENTS_IN_USE, CFG_DATA_WIDTH'($urandom_range(1, 16)));
      end else if (frag_w[p] >= 0) begin
        write_reg(REG_FRAGMENTS_IN_USE, CFG_DATA_WIDTH'(frag_w[p]));
      end
      if (len_w[p] == -2) begin
        write_reg(REG_CELLS_PER_FRAGMENT, CFG_DATA_WIDTH'($urandom_range(1, 16)));
      end else if (len_w[p] >= 0) begin
        write_reg(REG_CELLS_PER_FRAGMENT, CFG_DATA_WIDTH'(len_w[p]));
      end
      in_gap_pct = gap_w[p];
      out_stall_pct = stall_w[p];
      queue_random(count_w[p], 0);
      drain();
    end

    repeat (END_WAIT) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("tb_fragmented_sparse_array passed");
    end else begin
      $display("tb_fragmented_sparse_array failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fsa_pkg.sv
design/fsa_ram.sv
design/fragmented_sparse_array.sv
tb/tb_fragmented_sparse_array.sv
